@@ hw/rtl/pcts_pkg.sv @@
// ----------------------------------------------------------------------------
// pcts_pkg
// Types and constants shared by the priority class target selector.
// ----------------------------------------------------------------------------
package pcts_pkg;

    localparam int unsigned DIST_W   = 25;
    localparam int unsigned CLASS_W  = 4;
    localparam int unsigned RANK_W   = 3;
    localparam int unsigned PIX_W    = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ENTRY_W  = CLASS_W + RANK_W + DIST_W;

    localparam logic [RANK_W-1:0]    LOWEST_RANK  = 3'd6;
    localparam logic [PIX_W-1:0]     CENTER_X_RST = 11'd640;
    localparam logic [PIX_W-1:0]     CENTER_Y_RST = 11'd512;
    localparam logic [DIST_W-1:0]    DIST_MAX     = 25'h1FFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_CLASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd2;

    typedef struct packed {
        logic [3:0]  class_id;
        logic [10:0] box_x;
        logic [10:0] box_y;
        logic [10:0] box_w;
        logic [10:0] box_h;
        logic [3:0]  prev_class;
        logic        frame_end;
    } t_box;

    typedef struct packed {
        logic [3:0]  box_index;
        logic [3:0]  out_class;
        logic [24:0] dist_sq;
        logic [2:0]  rank;
        logic        last_out;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

@@ hw/rtl/pcts_ram.sv @@
// ----------------------------------------------------------------------------
// pcts_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/priority_class_target_selector.sv @@
// ----------------------------------------------------------------------------
// priority_class_target_selector
// Boxes: one per cycle while busy is low; each box passes a 3-stage distance
// pipeline before its entry is written to the entry RAM.
// Frame end: busy rises after the marked box; once that box has left the
// pipeline, each selection pass reads every stored entry once and emits one
// result, the nearest unsent best-rank entry. busy falls with the last result.
// Reset (synchronous): empty frame, best rank 6, top class 0, center 640/512.
// ----------------------------------------------------------------------------
module priority_class_target_selector #(
    parameter int unsigned MAX_BOXES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  pcts_pkg::t_box                i_box,
    output logic                          busy,
    output logic                          o_strobe,
    output pcts_pkg::t_result             o_res,
    input  logic                          i_cfg_we,
    input  logic [pcts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcts_pkg::PIX_W-1:0]    i_cfg_data
);
    import pcts_pkg::*;

    localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int unsigned CW = $clog2(MAX_BOXES + 1);

    // configuration
    logic [CLASS_W-1:0] r_top_class;
    logic [PIX_W-1:0]   r_center_x;
    logic [PIX_W-1:0]   r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_class <= '0;
            r_center_x  <= CENTER_X_RST;
            r_center_y  <= CENTER_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOP_CLASS: r_top_class <= i_cfg_data[CLASS_W-1:0];
                CFG_CENTER_X:  r_center_x  <= i_cfg_data;
                CFG_CENTER_Y:  r_center_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic   accept;
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // stages 1 and 2: rank and center offsets, then their squares
    logic              r_s1_vld, r_s2_vld;
    logic              r_s1_fend, r_s2_fend;
    logic [CLASS_W-1:0] r_s1_cls, r_s2_cls;
    logic [RANK_W-1:0] r_s1_rank, r_s2_rank;
    logic [12:0]       r_s1_dx, r_s1_dy;
    logic [25:0]       r_s2_sqx, r_s2_sqy;
    logic [RANK_W-1:0] n_rank;
    logic [12:0]       sum_x, sum_y, ctr_x, ctr_y;

    always_comb begin
        if (r_top_class != '0 && i_box.class_id == r_top_class) begin
            n_rank = 3'd0;
        end else if (i_box.class_id == i_box.prev_class) begin
            n_rank = 3'd1;
        end else begin
            case (i_box.class_id)
                4'd1:                n_rank = 3'd2;
                4'd3, 4'd4, 4'd5:    n_rank = 3'd3;
                4'd6:                n_rank = 3'd4;
                4'd8:                n_rank = 3'd5;
                default:             n_rank = LOWEST_RANK;
            endcase
        end
        // half-pixel box center against doubled aim point
        sum_x = {1'b0, i_box.box_x, 1'b0} + {2'b00, i_box.box_w};
        sum_y = {1'b0, i_box.box_y, 1'b0} + {2'b00, i_box.box_h};
        ctr_x = {1'b0, r_center_x, 1'b0};
        ctr_y = {1'b0, r_center_y, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_s1_cls  <= i_box.class_id;
        r_s1_rank <= n_rank;
        r_s1_fend <= i_box.frame_end;
        r_s1_dx   <= (sum_x >= ctr_x) ? (sum_x - ctr_x) : (ctr_x - sum_x);
        r_s1_dy   <= (sum_y >= ctr_y) ? (sum_y - ctr_y) : (ctr_y - sum_y);
        r_s2_cls  <= r_s1_cls;
        r_s2_rank <= r_s1_rank;
        r_s2_fend <= r_s1_fend;
        r_s2_sqx  <= r_s1_dx * r_s1_dx;
        r_s2_sqy  <= r_s1_dy * r_s1_dy;
    end

    // stage 3: saturate and write the entry
    logic [26:0]       dist_sum;
    logic [DIST_W-1:0] dist_sat;
    logic              wr_en;
    assign dist_sum = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
    assign dist_sat = (dist_sum > 27'(DIST_MAX)) ? DIST_MAX : dist_sum[DIST_W-1:0];

    logic [CW-1:0]     r_count;
    logic [RANK_W-1:0] r_best;
    logic [CW-1:0]     r_cand_cnt;   // entries holding the best rank
    logic [CW-1:0]     r_emit_cnt;
    assign wr_en = r_s2_vld && (r_count < CW'(MAX_BOXES));

    // selection scan
    logic [AW-1:0]      r_addr;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic [ENTRY_W-1:0] rd_data;
    logic [MAX_BOXES-1:0] r_done;
    logic               r_found, n_found;
    logic [DIST_W-1:0]  r_min, n_min;
    logic [AW-1:0]      r_sel, n_sel;
    logic [CLASS_W-1:0] r_sel_cls, n_sel_cls;
    logic [CLASS_W-1:0] rd_cls;
    logic [RANK_W-1:0]  rd_rank;
    logic [DIST_W-1:0]  rd_dist;
    logic               last_rd, last_emit;

    assign {rd_cls, rd_rank, rd_dist} = rd_data;
    assign last_rd   = (r_addr == AW'(r_count - CW'(1)));
    assign last_emit = (r_emit_cnt + CW'(1) == r_cand_cnt);

    pcts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_s2_cls, r_s2_rank, dist_sat}),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_found   = r_found;
        n_min     = r_min;
        n_sel     = r_sel;
        n_sel_cls = r_sel_cls;
        // strict compare keeps arrival order on equal distance
        if (r_rd_vld && rd_rank == r_best && !r_done[r_rd_idx]
                && (!r_found || rd_dist < r_min)) begin
            n_found   = 1'b1;
            n_min     = rd_dist;
            n_sel     = r_rd_idx;
            n_sel_cls = rd_cls;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept && i_box.frame_end) n_state = ST_DRAIN;
            ST_DRAIN: if (r_s2_vld && r_s2_fend)     n_state = ST_SCAN;
            ST_SCAN:  if (last_rd)                   n_state = ST_FIN;
            ST_FIN:   n_state = last_emit ? ST_IDLE : ST_SCAN;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_count    <= '0;
            r_best     <= LOWEST_RANK;
            r_cand_cnt <= '0;
            r_emit_cnt <= '0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_done     <= '0;
            r_found    <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            o_strobe <= (r_state == ST_FIN);
            r_rd_vld <= (r_state == ST_SCAN);
            r_found  <= (r_state == ST_FIN) ? 1'b0 : n_found;
            if (wr_en) begin
                r_count <= r_count + CW'(1);
                if (r_s2_rank < r_best) begin
                    r_best     <= r_s2_rank;
                    r_cand_cnt <= CW'(1);
                end else if (r_s2_rank == r_best) begin
                    r_cand_cnt <= r_cand_cnt + CW'(1);
                end
            end else if (r_state == ST_FIN && last_emit) begin
                r_count    <= '0;
                r_best     <= LOWEST_RANK;
                r_cand_cnt <= '0;
            end
            if (r_state == ST_SCAN) begin
                r_addr <= last_rd ? '0 : r_addr + AW'(1);
            end
            if (r_state == ST_FIN) begin
                if (last_emit) begin
                    r_emit_cnt <= '0;
                    r_done     <= '0;
                end else begin
                    r_emit_cnt    <= r_emit_cnt + CW'(1);
                    r_done[n_sel] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= r_addr;
        r_min     <= n_min;
        r_sel     <= n_sel;
        r_sel_cls <= n_sel_cls;
        if (r_state == ST_FIN) begin
            o_res.box_index <= 4'(n_sel);
            o_res.out_class <= n_sel_cls;
            o_res.dist_sq   <= n_min;
            o_res.rank      <= r_best;
            o_res.last_out  <= last_emit;
        end
    end

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last_out |-> busy)
        else $error("non-final result while idle");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_cnt <= r_cand_cnt)
        else $error("more results than candidates");
    a_fin_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |-> n_found)
        else $error("selection pass found no candidate");
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_res.rank <= LOWEST_RANK)
        else $error("result rank out of range");
`endif
endmodule
